[design/assert_macros.svh]
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked on every rising clock edge outside reset.
`define HZT_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define HZT_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HZT_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[design/hzt_pkg.sv]
package hzt_pkg;

  localparam int STAGES_DEF         = 8;
  localparam int DECODE_POS_DEF     = 2;
  localparam int FIRST_EXEC_POS_DEF = 3;
  localparam int COUNT_WIDTH_DEF    = 32;

  localparam int REG_COUNT = 32;
  localparam int REG_W     = $clog2(REG_COUNT);
  localparam int STAGE_W   = 3;
  localparam int ACTION_W  = 3;
  localparam int AMOUNT_W  = 4;
  localparam int OUT_W     = 32;

  localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_CHECK = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DEST  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_FLUSH = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_STALL = 3'd4;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_CHECK,
    CMD_DEST,
    CMD_FLUSH,
    CMD_STALL,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e                cmd;
    logic [REG_W-1:0]    reg_num;
    logic [STAGE_W-1:0]  stage;
    logic [AMOUNT_W-1:0] amount;
  } req_t;

endpackage

[design/hzt_front.sv]
module hzt_front import hzt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [REG_W-1:0]    reg_number_i,
  input  logic [STAGE_W-1:0]  stage_i,
  input  logic [AMOUNT_W-1:0] amount_i,
  output logic                req_valid_o,
  output req_t                req_o,
  input  logic                req_pop_i
);

  `include "assert_macros.svh"

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  req_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            push, pop;
  cmd_e            cmd;

  always_comb begin
    unique case (action_i)
      ACT_TICK:  cmd = CMD_TICK;
      ACT_CHECK: cmd = CMD_CHECK;
      ACT_DEST:  cmd = CMD_DEST;
      ACT_FLUSH: cmd = CMD_FLUSH;
      ACT_STALL: cmd = CMD_STALL;
      default:   cmd = CMD_NOP;
    endcase
  end

  assign busy        = (count_q == (PtrW+1)'(Depth));
  assign push        = start && !busy;
  assign req_valid_o = (count_q != '0);
  assign pop         = req_pop_i && req_valid_o;
  assign req_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{cmd: cmd, reg_num: reg_number_i, stage: stage_i,
                           amount: amount_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop)      count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  `HZT_ASSERT(a_count_range, clk_i, rst_ni, count_q <= (PtrW+1)'(Depth), "queue overfilled")
  `HZT_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, push && !pop, count_q == $past(count_q) + 1'b1, "push lost")
  `HZT_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, req_pop_i, req_valid_o, "pop from empty queue")

endmodule

[design/hzt_back.sv]
module hzt_back import hzt_pkg::*; #(
  parameter int STAGES         = STAGES_DEF,
  parameter int DECODE_POS     = DECODE_POS_DEF,
  parameter int FIRST_EXEC_POS = FIRST_EXEC_POS_DEF,
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  req_t               req_i,
  output logic               req_pop_o,
  output logic               result_valid_o,
  output logic               hazard_found_o,
  output logic [STAGE_W-1:0] hazard_stage_o,
  output logic [2:0]         bubbles_added_o,
  output logic [OUT_W-1:0]   cycle_total_o,
  output logic [OUT_W-1:0]   bubble_total_o,
  output logic [OUT_W-1:0]   flush_total_o,
  output logic [OUT_W-1:0]   hazard_total_o,
  output logic [OUT_W-1:0]   stall_total_o,
  output logic [OUT_W-1:0]   exe1_hazards_o,
  output logic [OUT_W-1:0]   exe2_hazards_o,
  output logic [OUT_W-1:0]   mem1_hazards_o,
  output logic [OUT_W-1:0]   mem2_hazards_o
);

  `include "assert_macros.svh"

  localparam int PosW = $clog2(STAGES);
  localparam int RemW = AMOUNT_W;
  localparam int CW   = COUNT_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_REPEAT = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic                bub_mode_q, bub_mode_d;
  logic                done_q, done_d;
  logic                found_q, found_d;
  logic [STAGE_W-1:0]  where_q, where_d;
  logic [2:0]          added_q, added_d;

  logic [STAGES-1:0]   slot_valid_q;
  logic [REG_W-1:0]    slot_reg_q   [STAGES];
  logic [STAGE_W-1:0]  slot_ready_q [STAGES];

  logic [CW-1:0]       cycle_q, bubble_q, flush_q, hazard_q, stall_q;
  logic [CW-1:0]       stage_cnt_q [4];

  logic                do_tick, do_bubble, do_flush, do_dest, do_hazard, do_stall;
  logic                do_stage_cnt;
  logic [1:0]          stage_idx;

  logic                hit;
  logic [PosW-1:0]     hit_pos;
  logic [STAGE_W-1:0]  hit_ready;
  logic [PosW-1:0]     hit_off;
  logic [PosW+2:0]     hit_pos_ext;
  logic signed [6:0]   n_s;
  logic                n_pos;

  function automatic logic [OUT_W-1:0] to_out(input logic [CW-1:0] v);
    logic [CW+OUT_W-1:0] ext;
    ext = {{OUT_W{1'b0}}, v};
    return ext[OUT_W-1:0];
  endfunction

  // Lowest position wins, so the loop runs from the back toward execute.
  always_comb begin
    hit       = 1'b0;
    hit_pos   = '0;
    hit_ready = '0;
    for (int i = STAGES - 2; i >= FIRST_EXEC_POS; i--) begin
      if (slot_valid_q[i] && slot_reg_q[i] == req_i.reg_num) begin
        hit       = 1'b1;
        hit_pos   = PosW'(i);
        hit_ready = slot_ready_q[i];
      end
    end
  end

  assign hit_off     = hit_pos - PosW'(FIRST_EXEC_POS);
  assign stage_idx   = hit_off[1:0];
  assign hit_pos_ext = {3'b000, hit_pos};
  assign n_s = 7'(hit_ready) - 7'(hit_pos) - 7'(req_i.stage) + 7'(DECODE_POS);
  assign n_pos = !n_s[6] && (n_s != '0);

  always_comb begin
    state_d      = state_q;
    rem_d        = rem_q;
    bub_mode_d   = bub_mode_q;
    done_d       = 1'b0;
    found_d      = found_q;
    where_d      = where_q;
    added_d      = added_q;
    req_pop_o    = 1'b0;
    do_tick      = 1'b0;
    do_bubble    = 1'b0;
    do_flush     = 1'b0;
    do_dest      = 1'b0;
    do_hazard    = 1'b0;
    do_stall     = 1'b0;
    do_stage_cnt = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          found_d   = 1'b0;
          where_d   = '0;
          added_d   = '0;
          done_d    = 1'b1;
          case (req_i.cmd)
            CMD_TICK: do_tick = 1'b1;
            CMD_CHECK: begin
              if (hit) begin
                found_d      = 1'b1;
                where_d      = hit_pos_ext[STAGE_W-1:0];
                do_hazard    = 1'b1;
                do_stage_cnt = (hit_off < PosW'(4));
                if (n_pos) begin
                  rem_d      = n_s[RemW-1:0];
                  added_d    = (n_s > 7'sd7) ? 3'd7 : n_s[2:0];
                  bub_mode_d = 1'b1;
                  state_d    = S_REPEAT;
                  done_d     = 1'b0;
                end
              end
            end
            CMD_DEST: do_dest = 1'b1;
            CMD_FLUSH: begin
              if (req_i.amount != '0) begin
                rem_d      = req_i.amount;
                bub_mode_d = 1'b0;
                state_d    = S_REPEAT;
                done_d     = 1'b0;
              end
            end
            CMD_STALL: do_stall = 1'b1;
            default: ;
          endcase
        end
      end
      S_REPEAT: begin
        if (bub_mode_q) begin
          do_bubble = 1'b1;
        end else begin
          do_tick  = 1'b1;
          do_flush = 1'b1;
        end
        rem_d = rem_q - 1'b1;
        if (rem_q == RemW'(1)) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rem_q      <= '0;
      bub_mode_q <= 1'b0;
      done_q     <= 1'b0;
      found_q    <= 1'b0;
      where_q    <= '0;
      added_q    <= '0;
      cycle_q    <= CW'(STAGES - 1);
      bubble_q   <= '0;
      flush_q    <= '0;
      hazard_q   <= '0;
      stall_q    <= '0;
      for (int k = 0; k < 4; k++) stage_cnt_q[k] <= '0;
    end else begin
      state_q    <= state_d;
      rem_q      <= rem_d;
      bub_mode_q <= bub_mode_d;
      done_q     <= done_d;
      found_q    <= found_d;
      where_q    <= where_d;
      added_q    <= added_d;
      if (do_tick || do_bubble) cycle_q <= cycle_q + 1'b1;
      if (do_bubble)            bubble_q <= bubble_q + 1'b1;
      if (do_flush)             flush_q <= flush_q + 1'b1;
      if (do_hazard)            hazard_q <= hazard_q + 1'b1;
      if (do_stall)             stall_q <= stall_q + CW'(req_i.amount);
      if (do_stage_cnt) stage_cnt_q[stage_idx] <= stage_cnt_q[stage_idx] + 1'b1;
    end
  end

  // A tick moves every slot down; a bubble opens a hole at the first
  // execute stage and leaves the front end where it is; a dest request fills the decode slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (do_tick) begin
      slot_valid_q <= {slot_valid_q[STAGES-2:0], 1'b0};
    end else if (do_bubble) begin
      for (int i = FIRST_EXEC_POS + 1; i < STAGES; i++) slot_valid_q[i] <= slot_valid_q[i-1];
      slot_valid_q[FIRST_EXEC_POS] <= 1'b0;
    end else if (do_dest) begin
      slot_valid_q[DECODE_POS] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_tick) begin
      for (int i = 1; i < STAGES; i++) begin
        slot_reg_q[i]   <= slot_reg_q[i-1];
        slot_ready_q[i] <= slot_ready_q[i-1];
      end
    end else if (do_bubble) begin
      for (int i = FIRST_EXEC_POS + 1; i < STAGES; i++) begin
        slot_reg_q[i]   <= slot_reg_q[i-1];
        slot_ready_q[i] <= slot_ready_q[i-1];
      end
    end else if (do_dest) begin
      slot_reg_q[DECODE_POS]   <= req_i.reg_num;
      slot_ready_q[DECODE_POS] <= req_i.stage;
    end
  end

  assign result_valid_o  = done_q;
  assign hazard_found_o  = found_q;
  assign hazard_stage_o  = where_q;
  assign bubbles_added_o = added_q;
  assign cycle_total_o   = to_out(cycle_q);
  assign bubble_total_o  = to_out(bubble_q);
  assign flush_total_o   = to_out(flush_q);
  assign hazard_total_o  = to_out(hazard_q);
  assign stall_total_o   = to_out(stall_q);
  assign exe1_hazards_o  = to_out(stage_cnt_q[0]);
  assign exe2_hazards_o  = to_out(stage_cnt_q[1]);
  assign mem1_hazards_o  = to_out(stage_cnt_q[2]);
  assign mem2_hazards_o  = to_out(stage_cnt_q[3]);

  `HZT_ASSERT_IMPL(a_repeat_rem, clk_i, rst_ni, state_q == S_REPEAT, rem_q != '0, "repeat with nothing left")
  `HZT_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, state_q == S_REPEAT && rem_q != RemW'(1), !done_q, "result before repeats end")
  `HZT_ASSERT_IMPL(a_no_pop_busy, clk_i, rst_ni, state_q == S_REPEAT, !req_pop_o, "request taken during repeats")

endmodule

[design/pipeline_raw_hazard_tracker_unit.sv]
// Channel   Direction  Handshake            Fields
// request   in         start / busy         action, reg_number, stage, amount
// result    out        result_valid_o pulse hazard flags, bubble count, counters
//
// A request waits in a two-entry queue and then takes one step in the executor,
// plus one repeat step per inserted bubble or per flush tick, counted down by
// the executor's repeat counter; no new request is taken until the repeats end.
// The result strobes for one cycle after the last step. Reset is asynchronous,
// active low, and empties the pipeline slots and the queue. busy rises only
// while the queue is full; results cannot be held off.
module pipeline_raw_hazard_tracker_unit import hzt_pkg::*; #(
  parameter int STAGES         = STAGES_DEF,
  parameter int DECODE_POS     = DECODE_POS_DEF,
  parameter int FIRST_EXEC_POS = FIRST_EXEC_POS_DEF,
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] action_i,
  input  logic [REG_W-1:0]    reg_number_i,
  input  logic [STAGE_W-1:0]  stage_i,
  input  logic [AMOUNT_W-1:0] amount_i,
  output logic                result_valid_o,
  output logic                hazard_found_o,
  output logic [STAGE_W-1:0]  hazard_stage_o,
  output logic [2:0]          bubbles_added_o,
  output logic [OUT_W-1:0]    cycle_total_o,
  output logic [OUT_W-1:0]    bubble_total_o,
  output logic [OUT_W-1:0]    flush_total_o,
  output logic [OUT_W-1:0]    hazard_total_o,
  output logic [OUT_W-1:0]    stall_total_o,
  output logic [OUT_W-1:0]    exe1_hazards_o,
  output logic [OUT_W-1:0]    exe2_hazards_o,
  output logic [OUT_W-1:0]    mem1_hazards_o,
  output logic [OUT_W-1:0]    mem2_hazards_o
);

  logic req_valid, req_pop;
  req_t req;

  hzt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .action_i     (action_i),
    .reg_number_i (reg_number_i),
    .stage_i      (stage_i),
    .amount_i     (amount_i),
    .req_valid_o  (req_valid),
    .req_o        (req),
    .req_pop_i    (req_pop)
  );

  hzt_back #(
    .STAGES         (STAGES),
    .DECODE_POS     (DECODE_POS),
    .FIRST_EXEC_POS (FIRST_EXEC_POS),
    .COUNT_WIDTH    (COUNT_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_valid),
    .req_i           (req),
    .req_pop_o       (req_pop),
    .result_valid_o  (result_valid_o),
    .hazard_found_o  (hazard_found_o),
    .hazard_stage_o  (hazard_stage_o),
    .bubbles_added_o (bubbles_added_o),
    .cycle_total_o   (cycle_total_o),
    .bubble_total_o  (bubble_total_o),
    .flush_total_o   (flush_total_o),
    .hazard_total_o  (hazard_total_o),
    .stall_total_o   (stall_total_o),
    .exe1_hazards_o  (exe1_hazards_o),
    .exe2_hazards_o  (exe2_hazards_o),
    .mem1_hazards_o  (mem1_hazards_o),
    .mem2_hazards_o  (mem2_hazards_o)
  );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import hzt_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;
  localparam int RANDOM_REQUESTS = 1100;
  localparam int CALM_TAIL       = 150;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [ACTION_W-1:0] action_i;
  logic [REG_W-1:0]    reg_number_i;
  logic [STAGE_W-1:0]  stage_i;
  logic [AMOUNT_W-1:0] amount_i;
  logic                result_valid_o;
  logic                hazard_found_o;
  logic [STAGE_W-1:0]  hazard_stage_o;
  logic [2:0]          bubbles_added_o;
  logic [OUT_W-1:0]    cycle_total_o;
  logic [OUT_W-1:0]    bubble_total_o;
  logic [OUT_W-1:0]    flush_total_o;
  logic [OUT_W-1:0]    hazard_total_o;
  logic [OUT_W-1:0]    stall_total_o;
  logic [OUT_W-1:0]    exe1_hazards_o;
  logic [OUT_W-1:0]    exe2_hazards_o;
  logic [OUT_W-1:0]    mem1_hazards_o;
  logic [OUT_W-1:0]    mem2_hazards_o;

  typedef struct packed {
    logic               found;
    logic [STAGE_W-1:0] where;
    logic [2:0]         added;
    logic [OUT_W-1:0]   cycles;
    logic [OUT_W-1:0]   bubbles;
    logic [OUT_W-1:0]   flushes;
    logic [OUT_W-1:0]   hazards;
    logic [OUT_W-1:0]   stalls;
    logic [OUT_W-1:0]   exe1;
    logic [OUT_W-1:0]   exe2;
    logic [OUT_W-1:0]   mem1;
    logic [OUT_W-1:0]   mem2;
  } tally_t;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [REG_W-1:0]    rnum;
    logic [STAGE_W-1:0]  stg;
    logic [AMOUNT_W-1:0] amt;
    logic                typed;
    logic                found;
    logic [STAGE_W-1:0]  where;
    logic [2:0]          added;
    logic [OUT_W-1:0]    cycles;
  } plan_row_t;

  // Shadow copy of the pipeline slots and the running counters.
  logic               pipe_valid [STAGES_DEF];
  logic [REG_W-1:0]   pipe_dest  [STAGES_DEF];
  logic [STAGE_W-1:0] pipe_ready [STAGES_DEF];
  logic [OUT_W-1:0]   n_cycles;
  logic [OUT_W-1:0]   n_bubbles;
  logic [OUT_W-1:0]   n_flushes;
  logic [OUT_W-1:0]   n_hazards;
  logic [OUT_W-1:0]   n_stalls;
  logic [OUT_W-1:0]   n_stage_hazards [4];

  tally_t    pending_tallies [$];
  plan_row_t plan_q [$];
  int        mismatches;

  pipeline_raw_hazard_tracker_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .reg_number_i   (reg_number_i),
    .stage_i        (stage_i),
    .amount_i       (amount_i),
    .result_valid_o (result_valid_o),
    .hazard_found_o (hazard_found_o),
    .hazard_stage_o (hazard_stage_o),
    .bubbles_added_o(bubbles_added_o),
    .cycle_total_o  (cycle_total_o),
    .bubble_total_o (bubble_total_o),
    .flush_total_o  (flush_total_o),
    .hazard_total_o (hazard_total_o),
    .stall_total_o  (stall_total_o),
    .exe1_hazards_o (exe1_hazards_o),
    .exe2_hazards_o (exe2_hazards_o),
    .mem1_hazards_o (mem1_hazards_o),
    .mem2_hazards_o (mem2_hazards_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Moves every slot above low one stage down and empties slot low.
  function automatic void shift_pipe(int low);
    for (int i = STAGES_DEF - 1; i > low; i--) begin
      pipe_valid[i] = pipe_valid[i-1];
      pipe_dest[i]  = pipe_dest[i-1];
      pipe_ready[i] = pipe_ready[i-1];
    end
    pipe_valid[low] = 1'b0;
    pipe_dest[low]  = '0;
    pipe_ready[low] = '0;
  endfunction

  function automatic tally_t predict_tally(logic [ACTION_W-1:0] act, logic [REG_W-1:0] rnum,
                                           logic [STAGE_W-1:0] stg, logic [AMOUNT_W-1:0] amt);
    tally_t t;
    bit     hit;
    int     till_result;
    int     till_needed;
    int     gap;
    t   = '0;
    hit = 1'b0;
    case (act)
      ACT_TICK: begin
        n_cycles = n_cycles + 1;
        shift_pipe(0);
      end
      ACT_CHECK: begin
        // The scan stops short of the last stage, whose result is already written back.
        for (int i = FIRST_EXEC_POS_DEF; i < STAGES_DEF - 1; i++) begin
          if (!hit && pipe_valid[i] && pipe_dest[i] == rnum) begin
            hit         = 1'b1;
            till_result = int'(pipe_ready[i]) - i;
            till_needed = int'(stg) - DECODE_POS_DEF;
            gap         = till_result - till_needed;
            t.found     = 1'b1;
            t.where     = STAGE_W'(i);
            n_hazards   = n_hazards + 1;
            if (i - FIRST_EXEC_POS_DEF < 4) begin
              n_stage_hazards[i-FIRST_EXEC_POS_DEF] = n_stage_hazards[i-FIRST_EXEC_POS_DEF] + 1;
            end
            for (int k = 0; k < gap; k++) begin
              n_cycles  = n_cycles + 1;
              n_bubbles = n_bubbles + 1;
              shift_pipe(FIRST_EXEC_POS_DEF);
            end
            if (gap > 0) begin
              t.added = (gap > 7) ? 3'd7 : 3'(gap);
            end
          end
        end
      end
      ACT_DEST: begin
        pipe_valid[DECODE_POS_DEF] = 1'b1;
        pipe_dest[DECODE_POS_DEF]  = rnum;
        pipe_ready[DECODE_POS_DEF] = stg;
      end
      ACT_FLUSH: begin
        for (int k = 0; k < int'(amt); k++) begin
          n_cycles  = n_cycles + 1;
          n_flushes = n_flushes + 1;
          shift_pipe(0);
        end
      end
      ACT_STALL: begin
        n_stalls = n_stalls + OUT_W'(amt);
      end
      default: begin
      end
    endcase
    t.cycles  = n_cycles;
    t.bubbles = n_bubbles;
    t.flushes = n_flushes;
    t.hazards = n_hazards;
    t.stalls  = n_stalls;
    t.exe1    = n_stage_hazards[0];
    t.exe2    = n_stage_hazards[1];
    t.mem1    = n_stage_hazards[2];
    t.mem2    = n_stage_hazards[3];
    return t;
  endfunction

  task automatic add_row(logic [ACTION_W-1:0] act, logic [REG_W-1:0] rnum,
                         logic [STAGE_W-1:0] stg, logic [AMOUNT_W-1:0] amt, logic typed,
                         logic found, logic [STAGE_W-1:0] where, logic [2:0] added,
                         logic [OUT_W-1:0] cycles);
    plan_q.push_back('{act, rnum, stg, amt, typed, found, where, added, cycles});
  endtask

  // Called right after a rising edge; returns at the edge that takes the request.
  task automatic issue_request(plan_row_t row);
    tally_t want;
    start        <= 1'b1;
    action_i     <= row.act;
    reg_number_i <= row.rnum;
    stage_i      <= row.stg;
    amount_i     <= row.amt;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    want = predict_tally(row.act, row.rnum, row.stg, row.amt);
    if (row.typed) begin
      want.found  = row.found;
      want.where  = row.where;
      want.added  = row.added;
      want.cycles = row.cycles;
    end
    pending_tallies.push_back(want);
  endtask

  task automatic pause_requests(int cycles);
    start        <= 1'b0;
    action_i     <= ACTION_W'($urandom);
    reg_number_i <= REG_W'($urandom);
    stage_i      <= STAGE_W'($urandom);
    amount_i     <= AMOUNT_W'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic compare_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    tally_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_tallies.size() == 0) begin
        $display("%0t ns: result strobe with no request outstanding", $time);
        mismatches++;
      end else begin
        want = pending_tallies.pop_front();
        compare_field("hazard_found", OUT_W'(want.found), OUT_W'(hazard_found_o));
        compare_field("hazard_stage", OUT_W'(want.where), OUT_W'(hazard_stage_o));
        compare_field("bubbles_added", OUT_W'(want.added), OUT_W'(bubbles_added_o));
        compare_field("cycle_total", want.cycles, cycle_total_o);
        compare_field("bubble_total", want.bubbles, bubble_total_o);
        compare_field("flush_total", want.flushes, flush_total_o);
        compare_field("hazard_total", want.hazards, hazard_total_o);
        compare_field("stall_total", want.stalls, stall_total_o);
        compare_field("exe1_hazards", want.exe1, exe1_hazards_o);
        compare_field("exe2_hazards", want.exe2, exe2_hazards_o);
        compare_field("mem1_hazards", want.mem1, mem1_hazards_o);
        compare_field("mem2_hazards", want.mem2, mem2_hazards_o);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL pipeline_raw_hazard_tracker_unit");
    $finish;
  end

  initial begin
    plan_row_t row;
    int        roll;
    int        pos;
    start        = 1'b0;
    action_i     = ACT_TICK;
    reg_number_i = '0;
    stage_i      = '0;
    amount_i     = '0;
    rst_ni       = 1'b0;
    mismatches   = 0;
    for (int i = 0; i < STAGES_DEF; i++) begin
      pipe_valid[i] = 1'b0;
      pipe_dest[i]  = '0;
      pipe_ready[i] = '0;
    end
    n_cycles  = OUT_W'(STAGES_DEF - 1);
    n_bubbles = '0;
    n_flushes = '0;
    n_hazards = '0;
    n_stalls  = '0;
    for (int i = 0; i < 4; i++) n_stage_hazards[i] = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The cycle count starts at seven, which covers the pipeline fill after reset.
    add_row(ACT_STALL, 5'd0, 3'd0, 4'd15, 1'b1, 1'b0, 3'd0, 3'd0, 32'd7);
    add_row(ACT_CHECK, 5'd0, 3'd0, 4'd0, 1'b1, 1'b0, 3'd0, 3'd0, 32'd7);
    add_row(ACT_TICK, 5'd0, 3'd0, 4'd0, 1'b1, 1'b0, 3'd0, 3'd0, 32'd8);
    add_row(ACT_SPARE_LAST, 5'd31, 3'd7, 4'd15, 1'b1, 1'b0, 3'd0, 3'd0, 32'd8);
    add_row(ACT_SPARE_FIRST, 5'd0, 3'd0, 4'd0, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_row(ACT_FLUSH, 5'd0, 3'd0, 4'd0, 1'b1, 1'b0, 3'd0, 3'd0, 32'd8);
    // Latest-ready producer against the earliest consumer gives the largest stall.
    add_row(ACT_DEST, 5'd31, 3'd7, 4'd0, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_row(ACT_TICK, 5'd0, 3'd0, 4'd0, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_row(ACT_CHECK, 5'd31, 3'd0, 4'd0, 1'b1, 1'b1, 3'd3, 3'd6, 32'd15);
    // A consumer that needs its operand late finds the value in time.
    add_row(ACT_DEST, 5'd0, 3'd0, 4'd0, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_row(ACT_TICK, 5'd0, 3'd0, 4'd0, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_row(ACT_CHECK, 5'd0, 3'd7, 4'd0, 1'b1, 1'b1, 3'd3, 3'd0, 32'd16);
    add_row(ACT_TICK, 5'd0, 3'd0, 4'd0, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_row(ACT_TICK, 5'd0, 3'd0, 4'd0, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_row(ACT_TICK, 5'd0, 3'd0, 4'd0, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_row(ACT_CHECK, 5'd0, 3'd2, 4'd0, 1'b1, 1'b1, 3'd6, 3'd0, 32'd19);
    // In the last stage the producer is out of the search window.
    add_row(ACT_TICK, 5'd0, 3'd0, 4'd0, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_row(ACT_CHECK, 5'd0, 3'd0, 4'd0, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_row(ACT_FLUSH, 5'd0, 3'd0, 4'd15, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    // Two producers of the same register: the lowest position wins.
    add_row(ACT_DEST, 5'd5, 3'd4, 4'd0, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_row(ACT_TICK, 5'd0, 3'd0, 4'd0, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_row(ACT_DEST, 5'd5, 3'd6, 4'd0, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_row(ACT_TICK, 5'd0, 3'd0, 4'd0, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    add_row(ACT_CHECK, 5'd5, 3'd2, 4'd0, 1'b1, 1'b1, 3'd3, 3'd3, 32'd40);
    add_row(ACT_CHECK, 5'd5, 3'd2, 4'd0, 1'b0, 1'b0, 3'd0, 3'd0, 32'd0);
    foreach (plan_q[i]) issue_request(plan_q[i]);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      row   = '0;
      roll  = $urandom_range(0, 99);
      row.rnum = REG_W'($urandom);
      row.stg  = STAGE_W'($urandom);
      row.amt  = AMOUNT_W'($urandom);
      if (roll < 28) begin
        row.act = ACT_TICK;
      end else if (roll < 52) begin
        row.act = ACT_DEST;
      end else if (roll < 82) begin
        // Mostly look up a register that is really in flight so hazards are frequent.
        row.act = ACT_CHECK;
        pos = $urandom_range(FIRST_EXEC_POS_DEF, STAGES_DEF - 2);
        if (pipe_valid[pos] && $urandom_range(0, 9) < 8) row.rnum = pipe_dest[pos];
      end else if (roll < 88) begin
        row.act = ACT_FLUSH;
        if ($urandom_range(0, 4) != 0) row.amt = AMOUNT_W'($urandom_range(0, 3));
      end else if (roll < 94) begin
        row.act = ACT_STALL;
      end else begin
        row.act = ACT_FLUSH + ACTION_W'($urandom_range(ACT_SPARE_FIRST - ACT_FLUSH,
                                                        ACT_SPARE_LAST - ACT_FLUSH));
      end
      issue_request(row);
      if (n < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
        pause_requests($urandom_range(1, 18));
      end
    end
    start <= 1'b0;

    while (pending_tallies.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS pipeline_raw_hazard_tracker_unit");
    end else begin
      $display("FAIL pipeline_raw_hazard_tracker_unit");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/hzt_pkg.sv
design/hzt_front.sv
design/hzt_back.sv
design/pipeline_raw_hazard_tracker_unit.sv
tb/sv/tb_top.sv
